// ===== src/efso_pkg.sv =====
// ----------------------------------------------------------------------------
// efso_pkg - shared types and constants of the FM sine oscillator
// Sequencer states, fixed-point constants, polynomial coefficients and the
// widths of the increment divider.
// ----------------------------------------------------------------------------
package efso_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_OCTAVE   = 3'd0;
	localparam logic [2:0] REG_FINE     = 3'd1;
	localparam logic [2:0] REG_HARMONIC = 3'd2;
	localparam logic [2:0] REG_SUBHARM  = 3'd3;
	localparam logic [2:0] REG_EXP_GAIN = 3'd4;
	localparam logic [2:0] REG_LIN_GAIN = 3'd5;
	localparam logic [2:0] REG_RATE     = 3'd6;

	// divider: 56-bit dividend (|F*harmonic| << 16), 23-bit divisor
	localparam int DVD_W  = 56;
	localparam int DVS_W  = 23;
	localparam int QCNT_W = 6;

	// log2(16.35 Hz) in Q12 octaves
	localparam logic signed [20:0] C0_Q12 = 21'sd16513;

	// Horner start values
	localparam logic signed [32:0] EXP_P0 = 33'sd16378;
	localparam logic signed [32:0] SIN_P0 = 33'sd172273;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_T2,
		ST_SIN,
		ST_SS,
		ST_SMP,
		ST_EXP,
		ST_FRQ,
		ST_HRM,
		ST_DST,
		ST_DIV,
		ST_WB,
		ST_DONE
	} efso_state_t;

	// exp2 mantissa coefficients, Q30, in Horner order
	function automatic logic signed [32:0] exp_coef(input logic [2:0] j);
		logic signed [32:0] c;
		unique case (j)
			3'd0:    c = 33'sd165394;
			3'd1:    c = 33'sd1431680;
			3'd2:    c = 33'sd10327388;
			3'd3:    c = 33'sd59597083;
			3'd4:    c = 33'sd257941248;
			3'd5:    c = 33'sd744261118;
			default: c = 33'sd1073741824;
		endcase
		return c;
	endfunction

	// quarter-wave sine coefficients in t^2, Q30, in Horner order
	function automatic logic signed [32:0] sin_coef(input logic [1:0] j);
		logic signed [32:0] c;
		unique case (j)
			2'd0: c = -33'sd5026995;
			2'd1: c = 33'sd85569306;
			2'd2: c = -33'sd693598670;
			2'd3: c = 33'sd1686629713;
		endcase
		return c;
	endfunction

endpackage

// ===== src/efso_div.sv =====
// ----------------------------------------------------------------------------
// efso_div - restoring divider for the phase increment
// Unsigned, one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module efso_div
	import efso_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W:0]    diff;
	logic              ge;

	// trial subtraction
	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign ge      = (shifted >= {1'b0, divisor});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == QCNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/exp_fm_sine_oscillator.sv =====
// ----------------------------------------------------------------------------
// exp_fm_sine_oscillator - polyphonic sine oscillator with exp and lin FM
// One request per voice sample; returns the sine at the voice phase and
// advances the phase by the FM-controlled increment.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one request per sample, tdata = voice, pitch_cv,
//   exp_fm_cv, lin_fm_cv. Master stream m_*: one result per request,
//   tdata = voice_out, sample.
//   Configuration: cfg_we/cfg_index/cfg_data, write only while idle.
// Timing:
//   One request at a time. The result loads in ST_DONE once the output is
//   free, and the next request is taken in the cycle after the load. Each
//   request runs the shared 32x31 multiplier (sine and exp2 Horner steps)
//   and the one-bit-per-cycle increment divider (56 quotient bits).
//   s_tready is high only while the sequencer is idle; a new request is
//   taken while the previous result still waits in the output register.
// Reset:
//   Control and configuration registers take their defaults, all voice
//   phases read as zero through per-voice valid bits, no clearing pass.
// Stall:
//   A held result blocks completion of the next request only; m_tdata and
//   m_tvalid hold until m_tready.
// ----------------------------------------------------------------------------
module exp_fm_sine_oscillator
	import efso_pkg::*;
#(
	parameter int VOICES          = 16,
	parameter int SINE_TABLE_SIZE = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// voice[3:0], pitch_cv[19:4], exp_fm_cv[35:20], lin_fm_cv[51:36], zero fill
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// voice_out[3:0], sample[19:4], zero fill
	output logic [23:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	localparam int IW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int TBL_W = $clog2(SINE_TABLE_SIZE);
	localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - TBL_W)) - 32'd1);

	efso_state_t state_q, state_d;

	// configuration registers
	logic [2:0]  octave_q;
	logic [11:0] fine_q;
	logic [4:0]  harm_q;
	logic [4:0]  sub_q;
	logic [11:0] egain_q;
	logic [11:0] lgain_q;
	logic [17:0] rate_q;

	// request fields
	logic [3:0]        in_voice;
	logic signed [15:0] in_pc, in_ec, in_lc;
	logic [IW-1:0]     in_idx;
	logic              in_acc;

	// working registers
	logic [3:0]         voice_q;
	logic [IW-1:0]      idx_q;
	logic               in_range_q;
	logic signed [15:0] pc_q;
	logic signed [28:0] eprod_q, lprod_q;
	logic [31:0]        rd_q;
	logic               vld_q;
	logic [31:0]        ph_q;
	logic [30:0]        t_q, t2_q;
	logic               neg_q;
	logic [29:0]        f_q;
	logic [4:0]         ui_q;
	logic signed [35:0] lterm_q;
	logic signed [32:0] acc_q, s_q;
	logic [2:0]         step_q;
	logic [15:0]        sample_q;
	logic signed [36:0] frq_q;
	logic signed [42:0] num_q;
	logic [3:0]         out_voice_q;
	logic [15:0]        out_sample_q;
	logic               m_tvalid_q;

	// phase memory and valid bits
	logic [31:0]       ph_mem [VOICES];
	logic [VOICES-1:0] pv_q;
	logic [31:0]       ph_new;
	logic [31:0]       inc;

	// sequencer outputs
	logic mem_we, div_start, out_load;

	// divider
	logic [DVS_W-1:0] base_den;
	logic [4:0]       sub_eff;
	logic [17:0]      rate_eff;
	logic [DVD_W-1:0] dvd;
	logic             div_done;
	logic [DVD_W-1:0] div_quo;

	// request unpack
	assign in_voice = s_tdata[3:0];
	assign in_pc    = s_tdata[19:4];
	assign in_ec    = s_tdata[35:20];
	assign in_lc    = s_tdata[51:36];
	assign in_idx   = IW'(in_voice);
	assign in_acc   = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_q <= 3'd3;
			fine_q   <= '0;
			harm_q   <= 5'd1;
			sub_q    <= 5'd1;
			egain_q  <= '0;
			lgain_q  <= '0;
			rate_q   <= 18'd48000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OCTAVE:   octave_q <= cfg_data[2:0];
				REG_FINE:     fine_q   <= cfg_data[11:0];
				REG_HARMONIC: harm_q   <= cfg_data[4:0];
				REG_SUBHARM:  sub_q    <= cfg_data[4:0];
				REG_EXP_GAIN: egain_q  <= cfg_data[11:0];
				REG_LIN_GAIN: lgain_q  <= cfg_data[11:0];
				REG_RATE:     rate_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// divisor: subharmonic * sample rate, zero taken as one
	assign sub_eff  = (sub_q == '0) ? 5'd1 : sub_q;
	assign rate_eff = (rate_q == '0) ? 18'd1 : rate_q;
	assign base_den = {18'd0, sub_eff} * {5'd0, rate_eff};

	// shared truncating multiplier: (a*b) >> 30 toward zero, b >= 0
	logic signed [32:0] mul_a;
	logic [30:0]        mul_b;
	logic [32:0]        mag_a;
	logic [62:0]        mprod;
	logic signed [32:0] mres;

	always_comb begin
		mul_a = acc_q;
		mul_b = t2_q;
		unique case (state_q)
			ST_T2:   begin mul_a = $signed({2'b00, t_q}); mul_b = t_q; end
			ST_SS:   mul_b = t_q;
			ST_EXP:  mul_b = {1'b0, f_q};
			default: ;
		endcase
	end

	assign mag_a = mul_a[32] ? -mul_a : mul_a;
	assign mprod = mag_a[31:0] * mul_b;
	assign mres  = mul_a[32] ? -$signed(mprod[62:30]) : $signed(mprod[62:30]);

	// exp2 argument and angle fold (prep stage)
	logic [31:0]        ph_rd, ang;
	logic [30:0]        t_low, t_fold;
	logic signed [20:0] xs;
	logic signed [16:0] xsat;
	logic [16:0]        xu;
	logic signed [39:0] lmul;

	assign ph_rd  = vld_q ? rd_q : 32'd0;
	assign ang    = ph_rd & ANG_MASK;
	assign t_low  = {1'b0, ang[29:0]};
	assign t_fold = ang[30] ? (31'h40000000 - t_low) : t_low;

	assign xs = C0_Q12 + $signed({6'd0, octave_q, 12'd0}) + $signed({9'd0, fine_q})
		+ $signed({{5{pc_q[15]}}, pc_q}) + eprod_q[28:8];

	always_comb begin
		if (xs < -21'sd65536)
			xsat = -17'sd65536;
		else if (xs > 21'sd65535)
			xsat = 17'sd65535;
		else
			xsat = xs[16:0];
	end

	assign xu   = {~xsat[16], xsat[15:0]};
	assign lmul = lprod_q * 40'sd1000;

	// sine scaling to Q1.15
	logic [31:0] s_pos;
	logic [46:0] s_scl;
	logic [16:0] s_rnd;
	logic [15:0] s_mag;

	assign s_pos = s_q[32] ? 32'd0 : s_q[31:0];
	assign s_scl = {15'd0, s_pos} * 47'd32767 + 47'd536870912;
	assign s_rnd = s_scl[46:30];
	assign s_mag = (s_rnd > 17'd32767) ? 16'd32767 : s_rnd[15:0];

	// exp2 result and total frequency
	logic [32:0] fexp;
	logic [4:0]  shamt;

	assign shamt = 5'd30 - ui_q;
	assign fexp  = (ui_q == 5'd31) ? {1'b0, acc_q[30:0], 1'b0}
		: ({2'b00, acc_q[30:0]} >> shamt);

	// divider operand
	logic signed [42:0] num_abs;

	assign num_abs = num_q[42] ? -num_q : num_q;
	assign dvd     = {num_abs[39:0], 16'd0};

	// increment clamp and new phase
	always_comb begin
		if (!num_q[42] && (div_quo > DVD_W'(64'h80000000)))
			inc = 32'h80000000;
		else if (num_q[42])
			inc = -div_quo[31:0];
		else
			inc = div_quo[31:0];
	end

	assign ph_new = ph_q + inc;

	efso_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (base_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_T2;
			ST_T2:   state_d = ST_SIN;
			ST_SIN:  if (step_q == 3'd3) state_d = ST_SS;
			ST_SS:   state_d = ST_SMP;
			ST_SMP:  state_d = ST_EXP;
			ST_EXP:  if (step_q == 3'd6) state_d = ST_FRQ;
			ST_FRQ:  state_d = ST_HRM;
			ST_HRM:  state_d = ST_DST;
			ST_DST: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV:  if (div_done) state_d = ST_WB;
			ST_WB: begin
				mem_we  = in_range_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				voice_q    <= in_voice;
				idx_q      <= in_idx;
				in_range_q <= (32'(in_voice) < VOICES);
				pc_q       <= in_pc;
				eprod_q    <= $signed({1'b0, egain_q}) * in_ec;
				lprod_q    <= $signed({1'b0, lgain_q}) * in_lc;
			end
			ST_PREP: begin
				ph_q    <= ph_rd;
				t_q     <= t_fold;
				neg_q   <= ang[31];
				f_q     <= {xu[11:0], 18'd0};
				ui_q    <= xu[16:12];
				lterm_q <= lmul[39:4];
			end
			ST_T2: begin
				t2_q   <= mres[30:0];
				acc_q  <= SIN_P0;
				step_q <= '0;
			end
			ST_SIN: begin
				acc_q  <= sin_coef(step_q[1:0]) + mres;
				step_q <= step_q + 1'b1;
			end
			ST_SS: s_q <= mres;
			ST_SMP: begin
				if (!in_range_q)
					sample_q <= '0;
				else
					sample_q <= neg_q ? -s_mag : s_mag;
				acc_q  <= EXP_P0;
				step_q <= '0;
			end
			ST_EXP: begin
				acc_q  <= exp_coef(step_q) + mres;
				step_q <= step_q + 1'b1;
			end
			ST_FRQ:  frq_q <= $signed({4'd0, fexp}) + {lterm_q[35], lterm_q};
			ST_HRM:  num_q <= frq_q * $signed({1'b0, harm_q});
			default: ;
		endcase
	end

	// phase memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			ph_mem[idx_q] <= ph_new;
		if (in_acc)
			rd_q <= ph_mem[in_idx];
	end

	// valid bits: unwritten voices read as phase zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			vld_q <= 1'b0;
		end else begin
			if (mem_we)
				pv_q[idx_q] <= 1'b1;
			if (in_acc)
				vld_q <= pv_q[in_idx];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_voice_q  <= voice_q;
			out_sample_q <= sample_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_sample_q, out_voice_q};

`ifndef ASSERT_OFF
	// phase written back only for voices that exist
	a_we_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> in_range_q)
		else $error("phase write for out-of-range voice");

	// out-of-range voice yields a zero sample
	a_zero_smp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !in_range_q) |=> (m_tdata[19:4] == 16'd0))
		else $error("nonzero sample for out-of-range voice");

	// one request in flight at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request accepted while busy");

	// positive increment never exceeds half a period
	a_inc_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !num_q[42]) |-> (inc <= 32'h80000000))
		else $error("increment above half period");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the FM sine oscillator
// Drives voice requests with random bursts and gaps, stalls the result side on
// its own pattern, predicts each sine sample and phase step with a local
// fixed-point model, and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
	import efso_pkg::*;

	localparam int  NVOICE    = 16;
	localparam int  TBL_SIZE  = 4096;
	localparam int  DRAIN_CYC = 200;
	localparam longint LIMIT  = 3000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;

	typedef struct packed {
		logic [3:0]         voice;
		logic signed [15:0] smp;
	} osc_out_t;

	// local copy of registers and phases
	logic [2:0]  r_octave;
	logic [11:0] r_fine;
	logic [4:0]  r_harm;
	logic [4:0]  r_subh;
	logic [11:0] r_egain;
	logic [11:0] r_lgain;
	logic [17:0] r_rate;
	logic [31:0] phase_mem [NVOICE];

	osc_out_t    sample_q[$];
	int          errors;
	int          burst_left;
	bit          no_gaps;
	bit          hold_req;
	int          hold_cnt;
	int          rdy_mode;
	longint      cycles;

	exp_fm_sine_oscillator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// product shifted right, truncated toward zero
	function automatic longint trunc_mul(longint a, longint b, int sh);
		bit                neg;
		longint unsigned   ma;
		longint unsigned   mb;
		longint unsigned   m;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? longint'(-a) : a;
		mb  = (b < 0) ? longint'(-b) : b;
		m   = (ma * mb) >> sh;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [15:0] sine_at(logic [31:0] ph);
		longint unsigned k;
		logic [31:0]     ang;
		longint          t;
		longint          t2;
		longint          p;
		longint          s;
		longint          v;
		k   = (longint'(ph) * TBL_SIZE) >> 32;
		ang = 32'((k << 32) / TBL_SIZE);
		t   = ang[29:0];
		if (ang[30])
			t = 64'd1073741824 - t;
		t2 = trunc_mul(t, t, 30);
		p  = 172273;
		p  = -5026995 + trunc_mul(p, t2, 30);
		p  = 85569306 + trunc_mul(p, t2, 30);
		p  = -693598670 + trunc_mul(p, t2, 30);
		p  = 1686629713 + trunc_mul(p, t2, 30);
		s  = trunc_mul(p, t, 30);
		if (s < 0)
			s = 0;
		v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (v > 32767)
			v = 32767;
		return ang[31] ? 16'(-v) : 16'(v);
	endfunction

	// 2^(x/4096) Hz in Q16, x already saturated
	function automatic longint pow2_hz(longint x);
		longint u;
		longint i;
		longint f;
		longint p;
		longint m;
		u = x + 65536;
		i = (u >>> 12) - 16;
		f = (u & 4095) << 18;
		p = 16378;
		p = 165394 + trunc_mul(p, f, 30);
		p = 1431680 + trunc_mul(p, f, 30);
		p = 10327388 + trunc_mul(p, f, 30);
		p = 59597083 + trunc_mul(p, f, 30);
		p = 257941248 + trunc_mul(p, f, 30);
		p = 744261118 + trunc_mul(p, f, 30);
		m = 64'sd1073741824 + trunc_mul(p, f, 30);
		if (i <= 14)
			return m >> (14 - i);
		return m << (i - 14);
	endfunction

	// expected sample for one request; advances the local phase
	function automatic osc_out_t next_sample(logic [3:0] v, logic signed [15:0] pc,
		logic signed [15:0] ec, logic signed [15:0] lc);
		osc_out_t    o;
		logic [31:0] ph;
		longint      x;
		longint      f;
		longint      den;
		longint      inc;
		o.voice = v;
		o.smp   = '0;
		if (v < NVOICE) begin
			ph    = phase_mem[v];
			o.smp = sine_at(ph);
			x = 16513 + longint'(r_octave) * 4096 + longint'(r_fine) + longint'(pc)
				+ ((longint'(r_egain) * longint'(ec)) >>> 8);
			if (x < -65536)
				x = -65536;
			if (x > 65535)
				x = 65535;
			f   = pow2_hz(x) + ((1000 * longint'(r_lgain) * longint'(lc)) >>> 4);
			den = longint'(r_subh == 0 ? 5'd1 : r_subh)
				* longint'(r_rate == 0 ? 18'd1 : r_rate);
			inc = (f * longint'(r_harm) * 65536) / den;
			if (inc > 64'sd2147483648)
				inc = 64'sd2147483648;
			phase_mem[v] = ph + 32'(inc);
		end
		return o;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL exp_fm_sine_oscillator");
			$finish;
		end
	end

	// result checker and stall pattern
	always @(posedge clk) begin
		osc_out_t got;
		osc_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.voice = m_tdata[3:0];
			got.smp   = m_tdata[19:4];
			if (sample_q.size() == 0) begin
				$display("%0t: unexpected result voice=%0d sample=%0d",
					$time, got.voice, got.smp);
				errors++;
			end else begin
				want = sample_q.pop_front();
				if (got.voice !== want.voice) begin
					$display("%0t: voice exp %0d got %0d", $time, want.voice, got.voice);
					errors++;
				end
				if (got.smp !== want.smp) begin
					$display("%0t: sample exp %0d got %0d (voice %0d)",
						$time, want.smp, got.smp, want.voice);
					errors++;
				end
			end
		end
		if (cycles % 300 == 0)
			rdy_mode = $urandom_range(0, 3);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 600;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 1);
				2: m_tready <= (cycles % 7 < 5);
				default: m_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// one request, with the burst and gap pattern in front of it
	task automatic send_req(logic [3:0] v, logic [15:0] pc, logic [15:0] ec,
		logic [15:0] lc);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, lc, ec, pc, v};
		do @(posedge clk); while (!s_tready);
		sample_q.push_back(next_sample(v, pc, ec, lc));
	endtask

	task automatic rand_req();
		logic [15:0] pc;
		logic [15:0] ec;
		logic [15:0] lc;
		// mostly musical control values, some full range
		if ($urandom_range(0, 3) == 0) begin
			pc = $urandom;
			ec = $urandom;
			lc = $urandom;
		end else begin
			pc = 16'($signed($urandom_range(0, 16384)) - 8192);
			ec = 16'($signed($urandom_range(0, 8192)) - 4096);
			lc = 16'($signed($urandom_range(0, 2048)) - 1024);
		end
		send_req(4'($urandom_range(0, NVOICE - 1)), pc, ec, lc);
	endtask

	// wait until every result is back and the block is idle
	task automatic drain();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [17:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_OCTAVE:   r_octave = val[2:0];
			REG_FINE:     r_fine   = val[11:0];
			REG_HARMONIC: r_harm   = val[4:0];
			REG_SUBHARM:  r_subh   = val[4:0];
			REG_EXP_GAIN: r_egain  = val[11:0];
			REG_LIN_GAIN: r_lgain  = val[11:0];
			REG_RATE:     r_rate   = val;
			default: ;
		endcase
	endtask

	task automatic set_all(int oct, int fine, int harm, int subh, int eg, int lg,
		int rate);
		write_reg(REG_OCTAVE, 18'(oct));
		write_reg(REG_FINE, 18'(fine));
		write_reg(REG_HARMONIC, 18'(harm));
		write_reg(REG_SUBHARM, 18'(subh));
		write_reg(REG_EXP_GAIN, 18'(eg));
		write_reg(REG_LIN_GAIN, 18'(lg));
		write_reg(REG_RATE, 18'(rate));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// field extremes under reset settings, then extreme settings
	task automatic test_directed();
		send_req(4'd0, 16'h0000, 16'h0000, 16'h0000);
		send_req(4'd15, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_req(4'd15, 16'h8000, 16'h8000, 16'h8000);
		send_req(4'd0, 16'h7FFF, 16'h0000, 16'h0000);
		send_req(4'd0, 16'h8000, 16'h0000, 16'h0000);
		send_req(4'd0, 16'h1000, 16'h0000, 16'h0000);
		drain();
		// max gains, max octave, fine and harmonic, top rate
		set_all(7, 4095, 31, 1, 4095, 4095, 262143);
		send_req(4'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_req(4'd1, 16'h8000, 16'h8000, 16'h8000);
		send_req(4'd1, 16'h0000, 16'h7FFF, 16'h8000);
		send_req(4'd1, 16'h0000, 16'h8000, 16'h7FFF);
		drain();
		// zero subharmonic, zero rate
		set_all(0, 0, 16, 0, 2560, 2560, 0);
		send_req(4'd2, 16'h0000, 16'h0000, 16'h0000);
		send_req(4'd2, 16'h8000, 16'h8000, 16'h8000);
		send_req(4'd2, 16'h7FFF, 16'h1000, 16'hF000);
		drain();
		// zero harmonic freezes the phase
		set_all(6, 2048, 0, 16, 0, 0, 8000);
		send_req(4'd3, 16'h7FFF, 16'h0000, 16'h0000);
		send_req(4'd3, 16'h7FFF, 16'h0000, 16'h0000);
		drain();
		// an index past the register list is ignored
		write_reg(3'd7, 18'h3FFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		set_all(3, 0, 1, 1, 0, 0, 48000);
		send_req(4'd3, 16'h0000, 16'h0000, 16'h0000);
		drain();
	endtask

	// random requests over a series of register settings
	task automatic test_random();
		for (int ph = 0; ph < 7; ph++) begin
			if (ph == 0)
				set_all(4, 100, 3, 2, 256, 256, 44100);
			else
				set_all($urandom_range(0, 7), $urandom_range(0, 4095),
					$urandom_range(0, 16), $urandom_range(0, 16),
					$urandom_range(0, 2560), $urandom_range(0, 2560),
					$urandom_range(8000, 192000));
			no_gaps = (ph % 3 == 1);
			repeat (170) rand_req();
			drain();
		end
	endtask

	// long receiver hold-off while requests keep coming
	task automatic test_backpressure();
		set_all(5, 0, 2, 3, 512, 1024, 96000);
		no_gaps  = 1'b1;
		hold_req = 1'b1;
		repeat (60) rand_req();
		no_gaps = 1'b0;
		drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		errors     = 0;
		burst_left = 0;
		no_gaps    = 1'b0;
		hold_req   = 1'b0;
		hold_cnt   = 0;
		rdy_mode   = 0;
		cycles     = 0;
		r_octave   = 3'd3;
		r_fine     = '0;
		r_harm     = 5'd1;
		r_subh     = 5'd1;
		r_egain    = '0;
		r_lgain    = '0;
		r_rate     = 18'd48000;
		foreach (phase_mem[i])
			phase_mem[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_backpressure();

		if (errors == 0)
			$display("PASS exp_fm_sine_oscillator");
		else
			$display("FAIL exp_fm_sine_oscillator");
		$finish;
	end

endmodule
